### hw/rtl/dwsr_pkg.sv
// Shared types, operation codes, register indexes and constants of the
// dual wheel speed regulator. No dependencies.
package dwsr_pkg;

    typedef logic [15:0] t_word;

    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_SET_SPEED    = 3'd1,
        OP_SKEW_LEFT    = 3'd2,
        OP_SKEW_RIGHT   = 3'd3,
        OP_MOVE_DIST    = 3'd4,
        OP_MOVE_ENDLESS = 3'd5,
        OP_TURN_DONE    = 3'd6,
        OP_NOP          = 3'd7
    } t_op;

    localparam logic [2:0] CFG_PWM_PERIOD    = 3'd0;
    localparam logic [2:0] CFG_SKEW_CORR     = 3'd1;
    localparam logic [2:0] CFG_SKEW_DAMP     = 3'd2;
    localparam logic [2:0] CFG_SKEW_BOOST    = 3'd3;
    localparam logic [2:0] CFG_STAB_TIMEOUT  = 3'd4;
    localparam logic [2:0] CFG_PULSES_PER_MM = 3'd5;

    localparam logic [15:0] RST_PWM_PERIOD    = 16'd255;
    localparam logic [6:0]  RST_SKEW_CORR     = 7'd20;
    localparam logic [6:0]  RST_SKEW_DAMP     = 7'd10;
    localparam logic [7:0]  RST_SKEW_BOOST    = 8'd20;
    localparam logic [14:0] RST_STAB_TIMEOUT  = 15'd500;
    localparam logic [15:0] RST_PULSES_PER_MM = 16'd256;

    // Division by 25 of a 16-bit value: (x * DIV25_MULT) >> DIV25_SHIFT is exact.
    localparam logic [16:0] DIV25_MULT  = 17'd83887;
    localparam int          DIV25_SHIFT = 21;

    // Division by 100 of a 24-bit value: estimate low by at most one, then correct.
    localparam logic [17:0] RECIP100      = 18'd167772;
    localparam int          RECIP100_SHIFT = 24;

    localparam logic [8:0] PCT_FULL    = 9'd100;
    localparam logic [7:0] BOOST_TRIM  = 8'd5;

endpackage

### hw/rtl/dwsr_wheel.sv
// One wheel's speed loop: error against target/25, drive accumulation and
// the saturated PWM compare. Depends on dwsr_pkg.
module dwsr_wheel (
    input  dwsr_pkg::t_word i_target,
    input  dwsr_pkg::t_word i_drive,
    input  dwsr_pkg::t_word i_pulses,
    input  logic [7:0]      i_boost,
    input  dwsr_pkg::t_word i_period,
    input  logic            i_tick,
    output dwsr_pkg::t_word o_drive_next,
    output dwsr_pkg::t_word o_compare
);
    import dwsr_pkg::*;

    logic [32:0] quot_prod;
    logic [7:0]  quot_low;
    logic [7:0]  err;
    t_word       drive_next;
    t_word       limited;
    logic [16:0] boosted;

    always_comb begin
        quot_prod  = {17'b0, i_target} * {16'b0, DIV25_MULT};
        quot_low   = quot_prod[DIV25_SHIFT +: 8];
        err        = quot_low - i_pulses[7:0];
        drive_next = i_tick ? (i_drive + {{8{err[7]}}, err}) : i_drive;
        limited    = (drive_next < i_period) ? drive_next : i_period;
        boosted    = {1'b0, limited} + {9'b0, i_boost};
    end

    assign o_drive_next = drive_next;
    assign o_compare    = boosted[16] ? 16'hFFFF : boosted[15:0];

endmodule

### hw/rtl/dual_wheel_speed_regulator.sv
// Top level of the dual wheel speed regulator: request channels, register
// file, regulator state and result register. Depends on dwsr_pkg, dwsr_wheel.
//
// Each accepted request is held in an input register, processed in a single
// pass and written to the result register once the result side can take it,
// and one request is taken in every cycle while the result side keeps up.
// The result register lets a new request be taken while the last result
// waits. The raised speed for skew correction comes from a product of speed
// and percentage that is kept registered beside the state. The user must
// write the registers only while no request is in flight; the block itself
// does not enforce it.
module dual_wheel_speed_regulator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_index,
    input  dwsr_pkg::t_word i_cfg_data,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_operation,
    input  logic [15:0]     i_pulses_left,
    input  logic [15:0]     i_pulses_right,
    input  logic            i_diagonals_on_line,
    input  dwsr_pkg::t_word i_speed,
    input  dwsr_pkg::t_word i_distance_mm,
    output logic            o_valid,
    input  logic            i_ready,
    output dwsr_pkg::t_word o_compare_left,
    output dwsr_pkg::t_word o_compare_right,
    output logic            o_motors_enabled,
    output logic            o_skew_correcting,
    output logic            o_turn_timeout_active,
    output logic [15:0]     o_remaining_pulses
);
    import dwsr_pkg::*;

    // Configuration registers.
    t_word       r_cfg_period, n_cfg_period;
    logic [6:0]  r_cfg_corr, n_cfg_corr;
    logic [6:0]  r_cfg_damp, n_cfg_damp;
    logic [7:0]  r_cfg_boost, n_cfg_boost;
    logic [14:0] r_cfg_timeout, n_cfg_timeout;
    t_word       r_cfg_ppm, n_cfg_ppm;

    // Input register.
    logic        r_in_valid;
    logic [2:0]  r_in_op;
    t_word       r_in_pl;
    t_word       r_in_pr;
    logic        r_in_diag;
    t_word       r_in_speed;
    t_word       r_in_dist;

    // Regulator state.
    t_word       r_drive_l, n_drive_l;
    t_word       r_drive_r, n_drive_r;
    t_word       r_target_l, n_target_l;
    t_word       r_target_r, n_target_r;
    t_word       r_cur, n_cur;
    t_word       r_dist, n_dist;
    t_word       r_stab, n_stab;
    logic [6:0]  r_damp, n_damp;
    logic [7:0]  r_boost_l, n_boost_l;
    logic [7:0]  r_boost_r, n_boost_r;
    logic        r_endless, n_endless;
    logic        r_skew, n_skew;
    logic        r_timeout, n_timeout;
    logic        r_done, n_done;
    logic [23:0] r_prod, n_prod;

    // Result register.
    logic        r_out_valid;
    t_word       r_cmp_l;
    t_word       r_cmp_r;
    logic        r_out_enabled;
    logic        r_out_skew;
    logic        r_out_timeout;
    t_word       r_out_dist;

    logic        advance;
    t_op         op;
    logic        tick;
    t_word       w_drive_l, w_drive_r, w_cmp_l, w_cmp_r;
    logic [7:0]  boost_sel_l, boost_sel_r;
    logic [7:0]  boost_val;
    logic [41:0] recip_prod;
    logic [17:0] q_est;
    logic [24:0] q_back;
    logic [24:0] q_rem;
    logic [17:0] q_fix;
    t_word       raised;
    logic [31:0] dist_prod;
    t_word       dist_pulses;
    logic [8:0]  factor;
    logic [7:0]  factor_clamped;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign op      = t_op'(r_in_op);
    assign tick    = (op == OP_TICK);

    assign boost_sel_l = tick ? r_boost_l : n_boost_l;
    assign boost_sel_r = tick ? r_boost_r : n_boost_r;

    dwsr_wheel u_wheel_l (
        .i_target     (r_target_l),
        .i_drive      (r_drive_l),
        .i_pulses     (r_in_pl),
        .i_boost      (boost_sel_l),
        .i_period     (r_cfg_period),
        .i_tick       (tick && advance),
        .o_drive_next (w_drive_l),
        .o_compare    (w_cmp_l)
    );

    dwsr_wheel u_wheel_r (
        .i_target     (r_target_r),
        .i_drive      (r_drive_r),
        .i_pulses     (r_in_pr),
        .i_boost      (boost_sel_r),
        .i_period     (r_cfg_period),
        .i_tick       (tick && advance),
        .o_drive_next (w_drive_r),
        .o_compare    (w_cmp_r)
    );

    always_comb begin
        n_cfg_period  = r_cfg_period;
        n_cfg_corr    = r_cfg_corr;
        n_cfg_damp    = r_cfg_damp;
        n_cfg_boost   = r_cfg_boost;
        n_cfg_timeout = r_cfg_timeout;
        n_cfg_ppm     = r_cfg_ppm;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PWM_PERIOD:    n_cfg_period  = i_cfg_data;
                CFG_SKEW_CORR:     n_cfg_corr    = i_cfg_data[6:0];
                CFG_SKEW_DAMP:     n_cfg_damp    = i_cfg_data[6:0];
                CFG_SKEW_BOOST:    n_cfg_boost   = i_cfg_data[7:0];
                CFG_STAB_TIMEOUT:  n_cfg_timeout = i_cfg_data[14:0];
                CFG_PULSES_PER_MM: n_cfg_ppm     = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        recip_prod = {18'b0, r_prod} * {24'b0, RECIP100};
        q_est      = recip_prod[RECIP100_SHIFT +: 18];
        q_back     = {7'b0, q_est} * 25'd100;
        q_rem      = {1'b0, r_prod} - q_back;
        q_fix      = q_est + {17'b0, (q_rem >= 25'd100)};
        raised     = (|q_fix[17:16]) ? 16'hFFFF : q_fix[15:0];

        if (r_timeout) begin
            boost_val = (r_cfg_boost >= BOOST_TRIM) ? (r_cfg_boost - BOOST_TRIM) : 8'd0;
        end else begin
            boost_val = r_cfg_boost;
        end

        dist_prod   = {16'b0, r_in_dist} * {16'b0, r_cfg_ppm};
        dist_pulses = (|dist_prod[31:23]) ? 16'h7FFF : {1'b0, dist_prod[22:8]};
    end

    always_comb begin
        n_drive_l  = w_drive_l;
        n_drive_r  = w_drive_r;
        n_target_l = r_target_l;
        n_target_r = r_target_r;
        n_cur      = r_cur;
        n_dist     = r_dist;
        n_stab     = r_stab;
        n_damp     = r_damp;
        n_boost_l  = r_boost_l;
        n_boost_r  = r_boost_r;
        n_endless  = r_endless;
        n_skew     = r_skew;
        n_timeout  = r_timeout;
        n_done     = r_done;
        if (advance) begin
            unique case (op)
                OP_TICK: begin
                    if ($signed(r_dist) > 16'sd0) begin
                        n_dist = r_dist - r_in_pl;
                    end
                    if (r_timeout) begin
                        if ($signed(r_stab) < $signed({1'b0, r_cfg_timeout})) begin
                            n_stab = r_stab + r_in_pl;
                        end else if (r_in_diag) begin
                            n_damp    = r_cfg_damp;
                            n_timeout = 1'b0;
                            n_stab    = '0;
                        end
                    end
                    if (!r_endless && ($signed(n_dist) <= 16'sd0)) begin
                        n_skew     = 1'b0;
                        n_boost_l  = '0;
                        n_boost_r  = '0;
                        n_cur      = '0;
                        n_target_l = '0;
                        n_target_r = '0;
                        n_done     = 1'b1;
                    end
                end
                OP_SET_SPEED: begin
                    n_skew     = 1'b0;
                    n_boost_l  = '0;
                    n_boost_r  = '0;
                    n_cur      = r_in_speed;
                    n_target_l = r_in_speed;
                    n_target_r = r_in_speed;
                end
                OP_SKEW_LEFT: begin
                    n_skew     = 1'b1;
                    n_boost_r  = boost_val;
                    n_boost_l  = '0;
                    n_target_r = raised;
                    n_target_l = r_cur;
                end
                OP_SKEW_RIGHT: begin
                    n_skew     = 1'b1;
                    n_boost_l  = boost_val;
                    n_boost_r  = '0;
                    n_target_l = raised;
                    n_target_r = r_cur;
                end
                OP_MOVE_DIST: begin
                    n_dist    = dist_pulses;
                    n_endless = 1'b0;
                    n_done    = 1'b0;
                end
                OP_MOVE_ENDLESS: begin
                    n_endless = 1'b1;
                    n_done    = 1'b0;
                end
                OP_TURN_DONE: begin
                    n_timeout = 1'b1;
                    n_stab    = '0;
                    n_damp    = '0;
                    n_boost_l = '0;
                    n_boost_r = '0;
                end
                default: ;
            endcase
        end
    end

    // The product for the raised speed follows the state it is built from.
    always_comb begin
        factor         = PCT_FULL + {2'b0, n_cfg_corr} - {2'b0, n_damp};
        factor_clamped = factor[8] ? 8'd0 : factor[7:0];
        n_prod         = {8'b0, n_cur} * {16'b0, factor_clamped};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_period  <= RST_PWM_PERIOD;
            r_cfg_corr    <= RST_SKEW_CORR;
            r_cfg_damp    <= RST_SKEW_DAMP;
            r_cfg_boost   <= RST_SKEW_BOOST;
            r_cfg_timeout <= RST_STAB_TIMEOUT;
            r_cfg_ppm     <= RST_PULSES_PER_MM;
            r_in_valid    <= 1'b0;
            r_drive_l     <= '0;
            r_drive_r     <= '0;
            r_target_l    <= '0;
            r_target_r    <= '0;
            r_cur         <= '0;
            r_dist        <= '0;
            r_stab        <= '0;
            r_damp        <= RST_SKEW_DAMP;
            r_boost_l     <= '0;
            r_boost_r     <= '0;
            r_endless     <= 1'b1;
            r_skew        <= 1'b0;
            r_timeout     <= 1'b0;
            r_done        <= 1'b0;
            r_prod        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cfg_period  <= n_cfg_period;
            r_cfg_corr    <= n_cfg_corr;
            r_cfg_damp    <= n_cfg_damp;
            r_cfg_boost   <= n_cfg_boost;
            r_cfg_timeout <= n_cfg_timeout;
            r_cfg_ppm     <= n_cfg_ppm;
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            r_drive_l  <= n_drive_l;
            r_drive_r  <= n_drive_r;
            r_target_l <= n_target_l;
            r_target_r <= n_target_r;
            r_cur      <= n_cur;
            r_dist     <= n_dist;
            r_stab     <= n_stab;
            r_damp     <= n_damp;
            r_boost_l  <= n_boost_l;
            r_boost_r  <= n_boost_r;
            r_endless  <= n_endless;
            r_skew     <= n_skew;
            r_timeout  <= n_timeout;
            r_done     <= n_done;
            r_prod     <= n_prod;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op    <= i_operation;
            r_in_pl    <= i_pulses_left;
            r_in_pr    <= i_pulses_right;
            r_in_diag  <= i_diagonals_on_line;
            r_in_speed <= i_speed;
            r_in_dist  <= i_distance_mm;
        end
        if (advance) begin
            r_cmp_l       <= w_cmp_l;
            r_cmp_r       <= w_cmp_r;
            r_out_enabled <= !n_done;
            r_out_skew    <= n_skew;
            r_out_timeout <= n_timeout;
            r_out_dist    <= n_dist;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_compare_left        = r_cmp_l;
    assign o_compare_right       = r_cmp_r;
    assign o_motors_enabled      = r_out_enabled;
    assign o_skew_correcting     = r_out_skew;
    assign o_turn_timeout_active = r_out_timeout;
    assign o_remaining_pulses    = r_out_dist;

endmodule
